### rtl/idt_pkg.sv
// types, constants and codes shared by the indentation tracker
// no dependencies

package idt_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int LEVEL_BITS  = 10;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);
  localparam int TAB_W       = 5;
  localparam int COUNT_W     = 5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam logic MODE_CHAR = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic [TAB_W-1:0] TAB_WEIGHT_RESET = TAB_W'(4);

  typedef enum logic [1:0] {
    EV_INDENT   = 2'd0,
    EV_DEDENT   = 2'd1,
    EV_INVALID  = 2'd2,
    EV_OVERFLOW = 2'd3
  } ev_kind_e;

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_HASH  = 2'd1,
    PH_SKIP  = 2'd2,
    PH_BODY  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_IDLE   = 2'd0,
    SEQ_TOP    = 2'd1,
    SEQ_SEARCH = 2'd2,
    SEQ_EMIT   = 2'd3
  } seq_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic       ends_logical_line;
  } in_item_t;

  typedef struct packed {
    ev_kind_e              event_kind;
    logic [COUNT_W-1:0]    dedent_count;
    logic [LEVEL_BITS-1:0] new_level;
  } out_item_t;

endpackage

### rtl/idt_if.sv
// valid/ready channel interfaces for input items, result items and config writes
// depends on idt_pkg

interface idt_in_if;
  logic             valid;
  logic             ready;
  idt_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface idt_out_if;
  logic               valid;
  logic               ready;
  idt_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface idt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [idt_pkg::TAB_W-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/indent_dedent_tracker_unit.sv
// indentation tracker top level: line phase, width count, level stack and search sequencer
// depends on idt_pkg and idt_if
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    mode, char_code, ends_logical_line
//   out_o    out  valid / ready    event_kind, dedent_count, new_level
//   cfg_i    in   valid / ready    tab_weight (always ready)
//
// a character that does not start a code line leaves the input ready for the next item
// the first code character reads the stack top: an equal level gives no result, a greater one an
// indent or overflow, a smaller one a search down the stack for a dedent or an invalid level
// the stack search uses the single read port of the level memory, one entry a cycle
// a result waits in the output register; items are taken meanwhile, and one that makes a
// result holds in emit, with the input not ready, until the register frees
// reset clears phase and width and sets fill to one; the stack memory needs no clearing pass

module indent_dedent_tracker_unit (
  input  logic clk_i,
  input  logic rst_ni,
  idt_in_if.sink    in_i,
  idt_out_if.source out_o,
  idt_cfg_if.sink   cfg_i
);
  import idt_pkg::*;

  localparam int SUM_W = LEVEL_BITS + 1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};

  logic [LEVEL_BITS-1:0] mem [STACK_DEPTH];

  logic [TAB_W-1:0]      tab_q;
  phase_e                phase_q, phase_d;
  seq_e                  seq_q, seq_d;
  logic [LEVEL_BITS-1:0] width_q, width_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  out_item_t             res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;
  logic [LEVEL_BITS-1:0] rd_data_q;
  logic                  rd_zero_q;

  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [LEVEL_BITS-1:0] rd_val;
  logic [TAB_W-1:0]      amount;
  logic                  add_en;
  logic [SUM_W-1:0]      sum;
  logic [FILL_W-1:0]     n_pop;
  logic                  accept;

  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;
  assign rd_val      = rd_zero_q ? '0 : rd_data_q;
  assign sum         = {1'b0, width_q} + SUM_W'(amount);
  assign n_pop       = fill_q - FILL_W'(1) - FILL_W'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q       <= TAB_WEIGHT_RESET;
      phase_q     <= PH_COUNT;
      seq_q       <= SEQ_IDLE;
      width_q     <= '0;
      fill_q      <= FILL_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        tab_q <= cfg_i.data;
      end
      phase_q     <= phase_d;
      seq_q       <= seq_d;
      width_q     <= width_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[IDX_W-1:0]] <= width_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_zero_q <= (rd_addr == '0);
    end
  end

  always_comb begin
    phase_d     = phase_q;
    seq_d       = seq_q;
    width_d     = width_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_item_d  = out_item_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = idx_q - IDX_W'(1);
    amount      = '0;
    add_en      = 1'b0;
    in_i.ready  = (seq_q == SEQ_IDLE);

    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          if (in_i.item.mode == MODE_END) begin
            phase_d = PH_COUNT;
            width_d = '0;
            fill_d  = FILL_W'(1);
          end else begin
            unique case (phase_q)
              PH_COUNT: begin
                case (in_i.item.char_code)
                  CH_SPACE: begin
                    amount = TAB_W'(1);
                    add_en = 1'b1;
                  end
                  CH_TAB: begin
                    amount = tab_q;
                    add_en = 1'b1;
                  end
                  CH_CR: ;
                  CH_LF:   width_d = '0;
                  CH_HASH: phase_d = PH_HASH;
                  default: begin
                    phase_d = PH_BODY;
                    seq_d   = SEQ_TOP;
                    rd_en   = 1'b1;
                    rd_addr = fill_q[IDX_W-1:0] - IDX_W'(1);
                  end
                endcase
              end
              PH_HASH: begin
                if (in_i.item.char_code == CH_COLON) begin
                  phase_d = PH_BODY;
                  seq_d   = SEQ_TOP;
                  rd_en   = 1'b1;
                  rd_addr = fill_q[IDX_W-1:0] - IDX_W'(1);
                end else if (in_i.item.char_code == CH_LF) begin
                  width_d = '0;
                  phase_d = PH_COUNT;
                end else begin
                  phase_d = PH_SKIP;
                end
              end
              PH_SKIP: begin
                if (in_i.item.char_code == CH_LF) begin
                  width_d = '0;
                  phase_d = PH_COUNT;
                end
              end
              PH_BODY: begin
                if (in_i.item.char_code == CH_LF && in_i.item.ends_logical_line) begin
                  width_d = '0;
                  phase_d = PH_COUNT;
                end
              end
            endcase
            if (add_en) begin
              width_d = (sum > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : sum[LEVEL_BITS-1:0];
            end
          end
          if (rd_en) begin
            idx_d = rd_addr;
          end
        end
      end
      SEQ_TOP, SEQ_SEARCH: begin
        res_d.new_level    = width_q;
        res_d.dedent_count = '0;
        res_d.event_kind   = EV_INVALID;
        if (seq_q == SEQ_TOP && width_q > rd_val) begin
          seq_d = SEQ_EMIT;
          if (fill_q == FILL_W'(STACK_DEPTH)) begin
            res_d.event_kind = EV_OVERFLOW;
          end else begin
            wr_en            = 1'b1;
            fill_d           = fill_q + FILL_W'(1);
            res_d.event_kind = EV_INDENT;
          end
        end else if (width_q == rd_val) begin
          if (seq_q == SEQ_TOP) begin
            seq_d = SEQ_IDLE;
          end else begin
            seq_d              = SEQ_EMIT;
            fill_d             = FILL_W'(idx_q) + FILL_W'(1);
            res_d.event_kind   = EV_DEDENT;
            res_d.dedent_count = (n_pop > FILL_W'({COUNT_W{1'b1}})) ?
                                 {COUNT_W{1'b1}} : COUNT_W'(n_pop);
          end
        end else if (idx_q == '0) begin
          seq_d = SEQ_EMIT;
        end else begin
          seq_d = SEQ_SEARCH;
          rd_en = 1'b1;
          idx_d = rd_addr;
        end
      end
      SEQ_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          seq_d       = SEQ_IDLE;
        end
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != '0) && (fill_q <= FILL_W'(STACK_DEPTH)))
    else $error("stack fill out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (fill_q == $past(fill_q) + FILL_W'(1)))
    else $error("push did not grow the stack");

  a_width_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SEQ_IDLE) |=> $stable(width_q))
    else $error("width changed during stack search");

  a_dedent_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_item_q.event_kind == EV_DEDENT) == (out_item_q.dedent_count != '0)))
    else $error("dedent count does not match event kind");

  a_no_busy_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_SEARCH) |-> !in_i.ready)
    else $error("input taken during stack search");
`endif

endmodule
